// ===== sv/token_position_embedding_engine_assert.svh =====
// assertion macros for the token plus position embedding engine
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef TOKEN_POSITION_EMBEDDING_ENGINE_ASSERT_SVH
`define TOKEN_POSITION_EMBEDDING_ENGINE_ASSERT_SVH

// property checked at every clock edge, off while in reset
`define TPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// when cond holds, expect holds at the next edge
`define TPE_ASSERT_NEXT(lbl, cond, expect_next, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cond) |=> (expect_next)) else $error(msg);

`endif

// ===== sv/tpe_pkg.sv =====
// shared types, op codes and saturating add for the embedding engine
// no dependencies
package tpe_pkg;

  localparam int unsigned VOCAB_DEF       = 512;
  localparam int unsigned MAX_POS_DEF     = 128;
  localparam int unsigned DIM_DEF         = 32;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned TOKEN_W  = 9;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned CHAN_W   = 5;
  localparam int unsigned DATA_W   = 32;

  // flat table index: row times stride plus channel, stride at most 4096
  localparam int unsigned TOK_IDX_W = 21;
  localparam int unsigned POS_IDX_W = 19;

  localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh80000000;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_TOK = 3'd0,
    OP_LOAD_POS = 3'd1,
    OP_FWD      = 3'd2,
    OP_BWD      = 3'd3,
    OP_RD_TOK   = 3'd4,
    OP_RD_POS   = 3'd5,
    OP_CLEAR    = 3'd6
  } op_e;

  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic [TOKEN_W-1:0]        token;
    logic [POS_W-1:0]          position;
    logic [CHAN_W-1:0]         channel;
    logic signed [DATA_W-1:0]  value;
    logic                      last_of_batch;
  } tpe_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  result;
    logic                      last;
  } tpe_out_t;

  // classified command handed from front to back
  typedef struct packed {
    op_e                       op;
    logic                      tok_ok;
    logic                      pos_ok;
    logic [TOK_IDX_W-1:0]      tok_idx;
    logic [POS_IDX_W-1:0]      pos_idx;
    logic signed [DATA_W-1:0]  value;
    logic                      last;
  } tpe_cmd_t;

  function automatic logic signed [DATA_W-1:0] sat_add(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b
  );
    logic [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) begin
      sat_add = s[DATA_W] ? SAT_MIN : SAT_MAX;
    end else begin
      sat_add = s[DATA_W-1:0];
    end
  endfunction

endpackage

// ===== sv/token_position_embedding_engine.sv =====
// token plus position embedding engine, top level: front, command queue, back
// a taken word passes the queue, the back part's command and read registers and the output register
// the back part pops a new word only after its read and execute steps for the last one are done
// clear words and reset each run a gradient sweep that zeroes both gradient tables
// reset is asynchronous active low; in_ready_o stays low until the reset sweep ends
module token_position_embedding_engine #(
  parameter int unsigned VOCAB       = tpe_pkg::VOCAB_DEF,
  parameter int unsigned MAX_POS     = tpe_pkg::MAX_POS_DEF,
  parameter int unsigned DIM         = tpe_pkg::DIM_DEF,
  parameter int unsigned QUEUE_DEPTH = tpe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tpe_pkg::tpe_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tpe_pkg::tpe_out_t  out_data_o
);
  import tpe_pkg::*;

  // classified words travel from front to back through the queue
  tpe_cmd_t push_data, head_data;
  logic     push, q_full, pop, q_empty;
  logic     init_busy;

  // front: range checks of token, position and channel, flat index build,
  // unknown op codes dropped at the door
  tpe_front #(
    .VOCAB   (VOCAB),
    .MAX_POS (MAX_POS),
    .DIM     (DIM)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .q_full_i    (q_full),
    .init_busy_i (init_busy),
    .q_push_o    (push),
    .q_data_o    (push_data)
  );

  // queue lets the front keep taking words while the back runs a clear sweep or stalls
  tpe_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (q_full),
    .pop_i   (pop),
    .data_o  (head_data),
    .empty_o (q_empty)
  );

  // back: memory reads on pop, then saturating add, write back or result;
  // result sits in an output register so the next word can be popped
  tpe_back #(
    .VOCAB   (VOCAB),
    .MAX_POS (MAX_POS),
    .DIM     (DIM)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (head_data),
    .q_pop_o     (pop),
    .init_busy_o (init_busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );
endmodule

// ===== sv/tpe_fifo.sv =====
// command queue between the front and back parts
// depends on tpe_pkg and the assertion macro header
`include "token_position_embedding_engine_assert.svh"

module tpe_fifo #(
  parameter int unsigned DEPTH = tpe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  tpe_pkg::tpe_cmd_t  data_i,
  output logic               full_o,
  input  logic               pop_i,
  output tpe_pkg::tpe_cmd_t  data_o,
  output logic               empty_o
);
  import tpe_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  tpe_cmd_t          mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + CNT_W'(push_i) - CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);

  `TPE_ASSERT(a_no_push_full, full_o |-> !push_i, "push into a full queue")
  `TPE_ASSERT(a_no_pop_empty, empty_o |-> !pop_i, "pop from an empty queue")
  `TPE_ASSERT_NEXT(a_cnt_up, push_i && !pop_i, cnt_q == $past(cnt_q) + 1'b1, "queue count lost")
endmodule

// ===== sv/tpe_front.sv =====
// front part: accepts input words, range checks them and builds table indexes
// depends on tpe_pkg
module tpe_front #(
  parameter int unsigned VOCAB   = tpe_pkg::VOCAB_DEF,
  parameter int unsigned MAX_POS = tpe_pkg::MAX_POS_DEF,
  parameter int unsigned DIM     = tpe_pkg::DIM_DEF
) (
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tpe_pkg::tpe_in_t   in_data_i,
  input  logic               q_full_i,
  input  logic               init_busy_i,
  output logic               q_push_o,
  output tpe_pkg::tpe_cmd_t  q_data_o
);
  import tpe_pkg::*;

  logic ch_ok, tok_ok, pos_ok, known_op;

  always_comb begin
    ch_ok    = 32'(in_data_i.channel) < DIM;
    tok_ok   = ch_ok && (32'(in_data_i.token) < VOCAB);
    pos_ok   = ch_ok && (32'(in_data_i.position) < MAX_POS);
    known_op = in_data_i.op inside {OP_LOAD_TOK, OP_LOAD_POS, OP_FWD, OP_BWD,
                                    OP_RD_TOK, OP_RD_POS, OP_CLEAR};

    q_data_o.op      = op_e'(in_data_i.op);
    q_data_o.tok_ok  = tok_ok;
    q_data_o.pos_ok  = pos_ok;
    q_data_o.tok_idx = tok_ok ? TOK_IDX_W'(in_data_i.token) * TOK_IDX_W'(DIM)
                                + TOK_IDX_W'(in_data_i.channel) : '0;
    q_data_o.pos_idx = pos_ok ? POS_IDX_W'(in_data_i.position) * POS_IDX_W'(DIM)
                                + POS_IDX_W'(in_data_i.channel) : '0;
    q_data_o.value   = in_data_i.value;
    q_data_o.last    = in_data_i.last_of_batch;
  end

  // unknown op codes are taken and dropped here
  assign in_ready_o = !q_full_i && !init_busy_i;
  assign q_push_o   = in_valid_i && in_ready_o && known_op;
endmodule

// ===== sv/tpe_back.sv =====
// back part: weight and gradient memories, execution sequencer, result register
// depends on tpe_pkg and the assertion macro header
`include "token_position_embedding_engine_assert.svh"

module tpe_back #(
  parameter int unsigned VOCAB   = tpe_pkg::VOCAB_DEF,
  parameter int unsigned MAX_POS = tpe_pkg::MAX_POS_DEF,
  parameter int unsigned DIM     = tpe_pkg::DIM_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  tpe_pkg::tpe_cmd_t  q_data_i,
  output logic               q_pop_o,
  output logic               init_busy_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tpe_pkg::tpe_out_t  out_data_o
);
  import tpe_pkg::*;

  // rows past the token and position field ranges can never be addressed
  localparam int unsigned TOK_ROWS  = (VOCAB < 2**TOKEN_W) ? VOCAB : 2**TOKEN_W;
  localparam int unsigned POS_ROWS  = (MAX_POS < 2**POS_W) ? MAX_POS : 2**POS_W;
  localparam int unsigned TOK_WORDS = TOK_ROWS * DIM;
  localparam int unsigned POS_WORDS = POS_ROWS * DIM;
  localparam int unsigned CLR_WORDS = (TOK_WORDS > POS_WORDS) ? TOK_WORDS : POS_WORDS;
  localparam int unsigned TA = (TOK_WORDS > 1) ? $clog2(TOK_WORDS) : 1;
  localparam int unsigned PA = (POS_WORDS > 1) ? $clog2(POS_WORDS) : 1;
  localparam int unsigned CA = (CLR_WORDS > 1) ? $clog2(CLR_WORDS) : 1;

  typedef enum logic [3:0] {
    S_INIT  = 4'b0001,
    S_IDLE  = 4'b0010,
    S_EXEC  = 4'b0100,
    S_CLEAR = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [CA-1:0]     clr_cnt_q, clr_cnt_d;
  logic              clr_last, clearing;
  tpe_cmd_t          cmd_q;
  logic              out_valid_q, out_valid_d;
  tpe_out_t          out_q;
  logic              has_result, exec_go;
  logic signed [DATA_W-1:0] res;

  logic signed [DATA_W-1:0] tw_mem [TOK_WORDS];
  logic signed [DATA_W-1:0] pw_mem [POS_WORDS];
  logic signed [DATA_W-1:0] tg_mem [TOK_WORDS];
  logic signed [DATA_W-1:0] pg_mem [POS_WORDS];
  logic signed [DATA_W-1:0] tw_rd_q, pw_rd_q, tg_rd_q, pg_rd_q;

  logic [TA-1:0] tok_ra, tok_wa, tg_wa;
  logic [PA-1:0] pos_ra, pos_wa, pg_wa;
  logic          tw_we, pw_we, tg_we, pg_we;
  logic signed [DATA_W-1:0] tg_wd, pg_wd;

  assign clr_last = (clr_cnt_q == CA'(CLR_WORDS - 1));
  assign clearing = (state_q == S_INIT) || (state_q == S_CLEAR);
  assign q_pop_o  = (state_q == S_IDLE) && !q_empty_i;
  assign tok_ra   = q_data_i.tok_idx[TA-1:0];
  assign pos_ra   = q_data_i.pos_idx[PA-1:0];
  assign tok_wa   = cmd_q.tok_idx[TA-1:0];
  assign pos_wa   = cmd_q.pos_idx[PA-1:0];

  always_comb begin
    has_result = 1'b0;
    res        = '0;
    case (cmd_q.op)
      OP_FWD: begin
        has_result = 1'b1;
        res = (cmd_q.tok_ok && cmd_q.pos_ok) ? sat_add(tw_rd_q, pw_rd_q) : '0;
      end
      OP_RD_TOK: begin
        has_result = 1'b1;
        res = cmd_q.tok_ok ? tg_rd_q : '0;
      end
      OP_RD_POS: begin
        has_result = 1'b1;
        res = cmd_q.pos_ok ? pg_rd_q : '0;
      end
      default: begin
        has_result = 1'b0;
      end
    endcase
  end

  // a result waits in exec until the output register has room
  assign exec_go = (state_q == S_EXEC) && (!has_result || !out_valid_q || out_ready_i);

  always_comb begin
    tw_we = exec_go && (cmd_q.op == OP_LOAD_TOK) && cmd_q.tok_ok;
    pw_we = exec_go && (cmd_q.op == OP_LOAD_POS) && cmd_q.pos_ok;
    if (clearing) begin
      tg_we = 32'(clr_cnt_q) < TOK_WORDS;
      pg_we = 32'(clr_cnt_q) < POS_WORDS;
      tg_wa = clr_cnt_q[TA-1:0];
      pg_wa = clr_cnt_q[PA-1:0];
      tg_wd = '0;
      pg_wd = '0;
    end else begin
      tg_we = exec_go && (cmd_q.op == OP_BWD) && cmd_q.tok_ok;
      pg_we = exec_go && (cmd_q.op == OP_BWD) && cmd_q.pos_ok;
      tg_wa = tok_wa;
      pg_wa = pos_wa;
      tg_wd = sat_add(tg_rd_q, cmd_q.value);
      pg_wd = sat_add(pg_rd_q, cmd_q.value);
    end
  end

  always_ff @(posedge clk_i) begin
    if (tw_we) begin
      tw_mem[tok_wa] <= cmd_q.value;
    end
    if (q_pop_o) begin
      tw_rd_q <= tw_mem[tok_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pw_we) begin
      pw_mem[pos_wa] <= cmd_q.value;
    end
    if (q_pop_o) begin
      pw_rd_q <= pw_mem[pos_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tg_we) begin
      tg_mem[tg_wa] <= tg_wd;
    end
    if (q_pop_o) begin
      tg_rd_q <= tg_mem[tok_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pg_we) begin
      pg_mem[pg_wa] <= pg_wd;
    end
    if (q_pop_o) begin
      pg_rd_q <= pg_mem[pos_ra];
    end
  end

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    case (state_q)
      S_INIT, S_CLEAR: begin
        clr_cnt_d = clr_last ? '0 : clr_cnt_q + 1'b1;
        if (clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!q_empty_i) begin
          state_d = (q_data_i.op == OP_CLEAR) ? S_CLEAR : S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    out_valid_d = (out_valid_q && !out_ready_i) || (exec_go && has_result);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cmd_q <= q_data_i;
    end
    if (exec_go && has_result) begin
      out_q.result <= res;
      out_q.last   <= cmd_q.last;
    end
  end

  assign init_busy_o = (state_q == S_INIT);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `TPE_ASSERT(a_no_result_in_init, (state_q == S_INIT) |-> !out_valid_q, "result during init clear")
  `TPE_ASSERT_NEXT(a_clear_ends, clearing && clr_last, state_q == S_IDLE, "clear sweep overran")
  `TPE_ASSERT_NEXT(a_exec_after_pop, q_pop_o && (q_data_i.op != OP_CLEAR), state_q == S_EXEC, "popped word not executed")
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// testbench for token_position_embedding_engine: directed and random words, each
// result checked against a behavioral copy of the four tables; needs tpe_pkg and the engine
module tb;
  import tpe_pkg::*;

  localparam int unsigned TOK_WORDS     = VOCAB_DEF * DIM_DEF;
  localparam int unsigned POS_WORDS     = MAX_POS_DEF * DIM_DEF;
  localparam int unsigned STALL_MAX     = 11;
  // longest quiet stretch: a gradient sweep under way plus four queued clear words
  // and a hold-off, with a wide margin on top
  localparam int unsigned IDLE_LIMIT    = 400000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned TAIL_CYCLES   = 20;
  localparam int unsigned MAX_ERR_LINES = 40;

  // clock, reset and the two word channels
  logic     clk_i     = 1'b0;
  logic     rst_ni    = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  tpe_in_t  in_word   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  tpe_out_t out_word;

  // idling controls shared between the stimulus and the receiver
  bit tx_idle_on  = 1'b0;
  bit rx_idle_on  = 1'b0;
  bit rx_hold_req = 1'b0;

  // behavioral copy of the tables
  logic signed [DATA_W-1:0] tok_weight [TOK_WORDS];
  logic signed [DATA_W-1:0] pos_weight [POS_WORDS];
  logic signed [DATA_W-1:0] tok_grad   [TOK_WORDS];
  logic signed [DATA_W-1:0] pos_grad   [POS_WORDS];
  // weight entries loaded so far, a forward word only reads these
  bit tok_loaded [TOK_WORDS];
  bit pos_loaded [POS_WORDS];
  int tok_loaded_list[$];
  int pos_loaded_list[$];

  // result words still owed by the engine, oldest first
  tpe_out_t pending_results[$];
  tpe_out_t oldest_result;

  int err_count   = 0;
  int n_sent      = 0;
  int n_checked   = 0;
  int n_forwards  = 0;
  int n_clears    = 0;
  int n_holds     = 0;

  always #10 clk_i = ~clk_i;

  token_position_embedding_engine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_word)
  );

  // one line per mismatch, printing capped so a broken build stays readable
  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    if (err_count < MAX_ERR_LINES) begin
      $display("mismatch at %0t: %s, got %h expected %h", $realtime, what, got, want);
    end
    err_count++;
  endtask

  // q8.24 add clipped to the signed 32-bit range
  function automatic logic signed [DATA_W-1:0] sat_sum(input logic signed [DATA_W-1:0] a,
                                                        input logic signed [DATA_W-1:0] b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > longint'(SAT_MAX)) return SAT_MAX;
    if (s < longint'(SAT_MIN)) return SAT_MIN;
    return s[DATA_W-1:0];
  endfunction

  // apply one accepted word to the tables, queue its result word if it has one
  task automatic update_tables(input tpe_in_t w);
    bit       ch_ok;
    bit       tok_ok;
    bit       pos_ok;
    bit       answers;
    int       ti;
    int       pi;
    tpe_out_t r;
    ch_ok   = w.channel < DIM_DEF;
    tok_ok  = ch_ok && (w.token < VOCAB_DEF);
    pos_ok  = ch_ok && (w.position < MAX_POS_DEF);
    ti      = tok_ok ? int'(w.token) * DIM_DEF + int'(w.channel) : 0;
    pi      = pos_ok ? int'(w.position) * DIM_DEF + int'(w.channel) : 0;
    r.result = '0;
    r.last   = w.last_of_batch;
    answers  = 1'b0;
    case (w.op)
      OP_LOAD_TOK: begin
        if (tok_ok) begin
          tok_weight[ti] = w.value;
          if (!tok_loaded[ti]) begin
            tok_loaded[ti] = 1'b1;
            tok_loaded_list.push_back(ti);
          end
        end
      end
      OP_LOAD_POS: begin
        if (pos_ok) begin
          pos_weight[pi] = w.value;
          if (!pos_loaded[pi]) begin
            pos_loaded[pi] = 1'b1;
            pos_loaded_list.push_back(pi);
          end
        end
      end
      OP_FWD: begin
        answers = 1'b1;
        if (tok_ok && pos_ok) r.result = sat_sum(tok_weight[ti], pos_weight[pi]);
      end
      OP_BWD: begin
        if (tok_ok) tok_grad[ti] = sat_sum(tok_grad[ti], w.value);
        if (pos_ok) pos_grad[pi] = sat_sum(pos_grad[pi], w.value);
      end
      OP_RD_TOK: begin
        answers = 1'b1;
        if (tok_ok) r.result = tok_grad[ti];
      end
      OP_RD_POS: begin
        answers = 1'b1;
        if (pos_ok) r.result = pos_grad[pi];
      end
      OP_CLEAR: begin
        foreach (tok_grad[i]) tok_grad[i] = '0;
        foreach (pos_grad[i]) pos_grad[i] = '0;
        n_clears++;
      end
      default: ;
    endcase
    if (answers) pending_results.push_back(r);
  endtask

  // offer one word after a random gap, hold it until taken, then predict
  task automatic send_word(input op_e op, input int tok, input int pos, input int ch,
                           input logic [DATA_W-1:0] val, input bit last);
    int      gap;
    tpe_in_t w;
    gap = tx_idle_on ? $urandom_range(0, STALL_MAX) : 0;
    w.op            = op;
    w.token         = tok[TOKEN_W-1:0];
    w.position      = pos[POS_W-1:0];
    w.channel       = ch[CHAN_W-1:0];
    w.value         = val;
    w.last_of_batch = last;
    if (gap > 0) begin
      if (in_valid) in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_word  <= w;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    update_tables(w);
    n_sent++;
  endtask

  // drop valid and pause the sender until every owed result has come back
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // addresses lean on a few rows at both ends of each table so words collide often
  function automatic int pick_token();
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 3) + ($urandom_range(0, 1) ? 508 : 0);
    return $urandom_range(0, VOCAB_DEF - 1);
  endfunction

  function automatic int pick_position();
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 3) + ($urandom_range(0, 1) ? 124 : 0);
    return $urandom_range(0, MAX_POS_DEF - 1);
  endfunction

  function automatic int pick_channel();
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 3) + ($urandom_range(0, 1) ? 28 : 0);
    return $urandom_range(0, DIM_DEF - 1);
  endfunction

  // mostly full-range words, some near the rails to drive saturation, some small
  function automatic logic [DATA_W-1:0] random_value();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k < 6) return $urandom;
    if (k < 8) begin
      if ($urandom_range(0, 1)) return 32'h7f00_0000 | ($urandom & 32'h00ff_ffff);
      return 32'h8000_0000 | ($urandom & 32'h00ff_ffff);
    end
    return $urandom_range(0, 511) - 256;
  endfunction

  // forward lookup on loaded entries only, loading a token or position word first if needed
  task automatic send_forward(input bit last);
    int  ti;
    int  tok;
    int  pos;
    int  ch;
    int  start;
    int  idx;
    bit  found;
    if (tok_loaded_list.size() == 0) begin
      send_word(OP_LOAD_TOK, pick_token(), pick_position(), pick_channel(), random_value(), 1'b0);
    end
    ti    = tok_loaded_list[$urandom_range(0, tok_loaded_list.size() - 1)];
    tok   = ti / DIM_DEF;
    ch    = ti % DIM_DEF;
    found = 1'b0;
    pos   = 0;
    start = $urandom_range(0, pos_loaded_list.size());
    for (int k = 0; k < pos_loaded_list.size() && !found; k++) begin
      idx = pos_loaded_list[(start + k) % pos_loaded_list.size()];
      if (idx % DIM_DEF == ch) begin
        found = 1'b1;
        pos   = idx / DIM_DEF;
      end
    end
    if (!found) begin
      pos = pick_position();
      send_word(OP_LOAD_POS, pick_token(), pos, ch, random_value(), 1'b0);
    end
    send_word(OP_FWD, tok, pos, ch, $urandom, last);
    n_forwards++;
  endtask

  task automatic send_random_word();
    int r;
    r = $urandom_range(0, 999);
    if (r < 130) begin
      send_word(OP_LOAD_TOK, pick_token(), pick_position(), pick_channel(), random_value(),
                1'($urandom_range(0, 1)));
    end else if (r < 260) begin
      send_word(OP_LOAD_POS, pick_token(), pick_position(), pick_channel(), random_value(),
                1'($urandom_range(0, 1)));
    end else if (r < 560) begin
      send_forward(1'($urandom_range(0, 1)));
    end else if (r < 780) begin
      send_word(OP_BWD, pick_token(), pick_position(), pick_channel(), random_value(),
                1'($urandom_range(0, 1)));
    end else if (r < 885) begin
      send_word(OP_RD_TOK, pick_token(), pick_position(), pick_channel(), $urandom,
                1'($urandom_range(0, 1)));
    end else if (r < 995) begin
      send_word(OP_RD_POS, pick_token(), pick_position(), pick_channel(), $urandom,
                1'($urandom_range(0, 1)));
    end else begin
      // rare, each clear costs a full gradient sweep
      send_word(OP_CLEAR, pick_token(), pick_position(), pick_channel(), $urandom,
                1'($urandom_range(0, 1)));
    end
  endtask

  // table corners and forward sums that clip at both rails
  task automatic test_weight_extremes();
    send_word(OP_LOAD_TOK, 0, 0, 0, SAT_MAX, 1'b0);
    send_word(OP_LOAD_POS, 0, 0, 0, SAT_MAX, 1'b1);
    send_word(OP_FWD, 0, 0, 0, '0, 1'b1);
    send_word(OP_LOAD_TOK, VOCAB_DEF - 1, 0, DIM_DEF - 1, SAT_MIN, 1'b0);
    send_word(OP_LOAD_POS, 0, MAX_POS_DEF - 1, DIM_DEF - 1, SAT_MIN, 1'b0);
    send_word(OP_FWD, VOCAB_DEF - 1, MAX_POS_DEF - 1, DIM_DEF - 1, 32'hffff_ffff, 1'b0);
    send_word(OP_LOAD_POS, 0, MAX_POS_DEF - 1, 0, SAT_MIN, 1'b1);
    send_word(OP_FWD, 0, MAX_POS_DEF - 1, 0, '0, 1'b0);
    send_word(OP_LOAD_TOK, VOCAB_DEF - 1, 0, 0, 32'hffff_ffff, 1'b0);
    send_word(OP_FWD, VOCAB_DEF - 1, 0, 0, '0, 1'b1);
    wait_results_drained();
  endtask

  // untouched gradients read zero, repeated backward words clip at both rails
  task automatic test_gradient_saturation();
    send_word(OP_RD_TOK, 5, 3, 7, '0, 1'b1);
    send_word(OP_BWD, 5, 3, 7, SAT_MAX, 1'b0);
    send_word(OP_BWD, 5, 3, 7, SAT_MAX, 1'b0);
    send_word(OP_RD_TOK, 5, 3, 7, '0, 1'b0);
    send_word(OP_RD_POS, 5, 3, 7, '0, 1'b1);
    send_word(OP_BWD, 6, 3, 7, SAT_MIN, 1'b0);
    send_word(OP_BWD, 6, 3, 7, SAT_MIN, 1'b1);
    send_word(OP_RD_POS, 6, 3, 7, '0, 1'b0);
    send_word(OP_RD_TOK, 6, 3, 7, '0, 1'b1);
    wait_results_drained();
  endtask

  // clear wipes both gradient tables, then read right behind a backward word
  task automatic test_gradient_clear();
    send_word(OP_CLEAR, 5, 3, 7, $urandom, 1'b0);
    send_word(OP_RD_TOK, 5, 3, 7, '0, 1'b0);
    send_word(OP_RD_POS, 5, 3, 7, '0, 1'b1);
    send_word(OP_BWD, 5, 3, 7, 32'h0000_0001, 1'b0);
    send_word(OP_RD_TOK, 5, 3, 7, '0, 1'b1);
    send_word(OP_RD_POS, 5, 3, 7, '0, 1'b0);
    wait_results_drained();
  endtask

  // receiver holds off while the sender keeps going, so the engine backs up
  task automatic test_output_stall();
    tx_idle_on  = 1'b0;
    rx_hold_req = 1'b1;
    for (int k = 0; k < 24; k++) send_forward(1'($urandom_range(0, 1)));
    wait_results_drained();
  endtask

  // segments with a fresh idling mix each, now and then a full pause
  task automatic test_random_traffic();
    for (int seg = 0; seg < 20; seg++) begin
      tx_idle_on = $urandom_range(0, 3) != 0;
      rx_idle_on = $urandom_range(0, 3) != 0;
      for (int k = 0; k < 50; k++) send_random_word();
      if ($urandom_range(0, 4) == 0) wait_results_drained();
    end
  endtask

  // result receiver: random stall per word, or a long hold when asked
  initial begin : result_receiver
    int stall;
    @(posedge rst_ni);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        n_holds++;
      end else begin
        stall = rx_idle_on ? $urandom_range(0, STALL_MAX) : 0;
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      out_ready <= 1'b1;
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
    end
  end

  // each taken result word against the oldest owed one, field by field
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word with nothing owed", out_word.result, '0);
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_word.result !== oldest_result.result) begin
          report_mismatch("result field", out_word.result, oldest_result.result);
        end
        if (out_word.last !== oldest_result.last) begin
          report_mismatch("last field", 32'(out_word.last), 32'(oldest_result.last));
        end
        n_checked++;
      end
    end
  end

  // ends the run when no word moves on either channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : main_sequence
    // gradients come out of reset zeroed, weights stay unread until loaded
    foreach (tok_grad[i]) tok_grad[i] = '0;
    foreach (pos_grad[i]) pos_grad[i] = '0;
    foreach (tok_weight[i]) tok_weight[i] = '0;
    foreach (pos_weight[i]) pos_weight[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_weight_extremes();
    test_gradient_saturation();
    test_gradient_clear();
    test_output_stall();
    test_random_traffic();

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      report_mismatch("result words never delivered", pending_results.size(), '0);
    end

    $display("run covered %0d words in, %0d results checked, %0d forward lookups",
             n_sent, n_checked, n_forwards);
    $display("with %0d gradient clears, %0d receiver hold-offs, %0d mismatches",
             n_clears, n_holds, err_count);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
